// ===== rtl/core/tpmt_pkg.sv =====
// Shared types and constants for the tolerance path match table.
package tpmt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 128;
   localparam int COORD_W             = 32;
   localparam int ENTRY_W             = 4 * COORD_W + 1;
   localparam int TOL_W               = 31;

   localparam logic [TOL_W-1:0] TOL_RESET = 31'd6554;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } fsm_state_type;

endpackage

// ===== rtl/core/tolerance_path_match_table.sv =====
// Route table with appends, clears and in-order tolerance search.
//
// Input channel req_*: one beat per command (clear, append, search); the
// command code rides in req_tuser, the route or query in req_tdata.
// Result channel rsp_*: exactly one beat per command, in order.
// Configuration: csr_wr_en writes match_tolerance; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Routes live in a single synchronous memory, one entry per route. Clear,
// append and the unused command code finish in the accept cycle; their
// result is valid on the next cycle. A search reads one stored entry per
// cycle through a two-stage compare pipeline (difference magnitudes, then
// bound test) and stops at the first match or after the last stored entry.
// One command is in progress at a time; a new beat is taken once the
// result register is free or being emptied in the same cycle.
// A stalled receiver holds the result register and, for a search, the
// finished result waits until the register frees.
// Reset (synchronous) empties the table, restores the tolerance to 6554
// and drops any pending result; entry contents are not cleared.
module tolerance_path_match_table
   import tpmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] start_x, [63:32] start_y, [95:64] end_x, [127:96] end_y,
   // [128] route_valid, [135:129] zero
   input  logic [135:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] found, [7:1] match_index, [8] dropped, [16:9] route_count,
   // [23:17] zero
   output logic [23:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

   fsm_state_type state_ff, state_in;
   logic [TOL_W-1:0]   tol_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff;
   logic [COORD_W-1:0] q_ff [4];

   logic               rd_vld_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               s1_vld_ff;
   logic               s1_ok_ff;
   logic [IW-1:0]      s1_idx_ff;
   logic [COORD_W:0]   s1_mag_ff [4];

   logic               res_found_ff;
   logic [IW-1:0]      res_idx_ff;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [6:0]         rsp_idx_ff;
   logic               rsp_drop_ff;
   logic [7:0]         rsp_count_ff;

   logic               accept;
   logic               slot_free;
   logic               issue;
   logic               hit_now;
   logic               scan_end;
   logic               load_idle;
   logic               load_done;
   logic               full;
   logic [3:0]         lane_ok;
   logic [COORD_W:0]   mag_in [4];

   assign accept    = req_tvalid & req_tready;
   assign slot_free = ~rsp_valid_ff | rsp_tready;
   assign full      = (count_ff >= DEPTH_C);

   // difference magnitudes, 33 bits so nothing wraps
   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [COORD_W:0] a_ext, b_ext, dp, dn;
      assign a_ext     = {rd_data_ff[COORD_W*k+COORD_W-1], rd_data_ff[COORD_W*k +: COORD_W]};
      assign b_ext     = {q_ff[k][COORD_W-1], q_ff[k]};
      assign dp        = a_ext - b_ext;
      assign dn        = b_ext - a_ext;
      assign mag_in[k] = dp[COORD_W] ? dn : dp;
      assign lane_ok[k] = (s1_mag_ff[k] < {2'b00, tol_ff});
   end

   assign hit_now  = (state_ff == ST_SCAN) & s1_vld_ff & s1_ok_ff & (&lane_ok);
   assign scan_end = ~hit_now & (ptr_ff == count_ff) & ~rd_vld_ff & ~s1_vld_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == CMD_SEARCH) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit_now || scan_end) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      load_done  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = slot_free;
         ST_SCAN: issue      = (ptr_ff < count_ff) & ~hit_now;
         ST_DONE: load_done  = slot_free;
         default: req_tready = 1'b0;
      endcase
   end

   assign load_idle = accept & (req_tuser != CMD_SEARCH);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (req_tuser)
            CMD_CLEAR:  count_in = '0;
            CMD_APPEND: if (!full) count_in = count_ff + 1'b1;
            default:    count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff   <= TOL_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) tol_ff <= csr_wr_data;
      end
   end

   // table memory: write on append, registered read during a scan
   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_APPEND && !full)
         mem[count_ff[IW-1:0]] <= req_tdata[ENTRY_W-1:0];
      if (issue)
         rd_data_ff <= mem[ptr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_SEARCH) begin
         ptr_ff <= '0;
         for (int k = 0; k < 4; k++) q_ff[k] <= req_tdata[COORD_W*k +: COORD_W];
      end else if (issue) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
      if (issue) rd_idx_ff <= ptr_ff[IW-1:0];
      if (rd_vld_ff) begin
         s1_ok_ff  <= rd_data_ff[ENTRY_W-1];
         s1_idx_ff <= rd_idx_ff;
         for (int k = 0; k < 4; k++) s1_mag_ff[k] <= mag_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         s1_vld_ff <= rd_vld_ff & ~hit_now & (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_SEARCH) begin
         res_found_ff <= 1'b0;
         res_idx_ff   <= '0;
      end else if (hit_now) begin
         res_found_ff <= 1'b1;
         res_idx_ff   <= s1_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_idle || load_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_idle) begin
         rsp_found_ff <= 1'b0;
         rsp_idx_ff   <= '0;
         rsp_drop_ff  <= (req_tuser == CMD_APPEND) & full;
         rsp_count_ff <= 8'(count_in);
      end else if (load_done) begin
         rsp_found_ff <= res_found_ff;
         rsp_idx_ff   <= 7'(res_idx_ff);
         rsp_drop_ff  <= 1'b0;
         rsp_count_ff <= 8'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_drop_ff, rsp_idx_ff, rsp_found_ff};

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (load_idle || load_done) |-> slot_free)
      else $error("result register overwritten while held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stored count beyond table depth");

   a_search_enters_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == CMD_SEARCH) |=> (state_ff == ST_SCAN))
      else $error("search accepted but scan not started");

   a_hit_then_done: assert property (@(posedge clock) disable iff (reset)
      hit_now |=> (state_ff == ST_DONE) && res_found_ff)
      else $error("match not recorded");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |=> rd_vld_ff && (rd_idx_ff == $past(ptr_ff[IW-1:0])))
      else $error("read pipeline lost an entry");
`endif

endmodule

// ===== tb/tolerance_path_match_table_tb.sv =====
// Self-checking testbench for the tolerance path match table: directed rows, then random phases.
`timescale 1ns / 1ps

module tolerance_path_match_table_tb;
   import tpmt_pkg::*;

   localparam int          TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;
   localparam logic [31:0] COORD_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_MIN   = 32'h8000_0000;
   localparam int          ITEM_TARGET = 800;
   localparam longint      CYCLE_LIMIT = 1_000_000;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic               vmark;
   } route_cmd_type;

   typedef struct packed {
      logic [7:0] count;
      logic       dropped;
      logic [6:0] idx;
      logic       found;
   } route_reply_type;

   typedef struct {
      route_cmd_type   c;
      bit              typed;
      route_reply_type r;
   } stim_row_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   // [31:0] start_x, [63:32] start_y, [95:64] end_x, [127:96] end_y,
   // [128] route_valid, [135:129] zero
   logic [135:0] req_tdata   = '0;
   // [1:0] cmd
   logic [1:0]   req_tuser   = CMD_CLEAR;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   // [0] found, [7:1] match_index, [8] dropped, [16:9] route_count, [23:17] zero
   logic [23:0]  rsp_tdata;
   logic         csr_wr_en   = 1'b0;
   logic [30:0]  csr_wr_data = '0;

   route_cmd_type   route_tbl[TABLE_DEPTH];
   int              route_count = 0;
   logic [30:0]     tol_model   = TOL_RESET;
   route_reply_type reply_q[$];
   stim_row_type    rows[$];

   int     items_sent  = 0;
   int     rsp_seen    = 0;
   int     error_count = 0;
   longint cycle_count = 0;
   bit     idle_on     = 1'b1;
   bit     hold_done   = 1'b0;

   tolerance_path_match_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at reply %0d: got %0d, want %0d", field, rsp_seen, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic bit coord_close(input logic signed [31:0] a, input logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d < longint'(tol_model);
   endfunction

   // Applies one command to the table copy and returns the reply it yields.
   function automatic route_reply_type predict_route_reply(input route_cmd_type c);
      route_reply_type r;
      bit hit;
      r = '0;
      hit = 1'b0;
      case (c.cmd)
         CMD_CLEAR: route_count = 0;
         CMD_APPEND: begin
            if (route_count < TABLE_DEPTH) begin
               route_tbl[route_count] = c;
               route_count++;
            end else begin
               r.dropped = 1'b1;
            end
         end
         CMD_SEARCH: begin
            for (int i = 0; i < route_count; i++) begin
               if (!hit && route_tbl[i].vmark &&
                   coord_close(route_tbl[i].sx, c.sx) && coord_close(route_tbl[i].sy, c.sy) &&
                   coord_close(route_tbl[i].ex, c.ex) && coord_close(route_tbl[i].ey, c.ey)) begin
                  hit = 1'b1;
                  r.found = 1'b1;
                  r.idx = i[6:0];
               end
            end
         end
         default: ;
      endcase
      r.count = route_count[7:0];
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         default: return $urandom;
      endcase
   endfunction

   // Keeps a coordinate or moves it just inside or outside the tolerance, or up to 65536 away.
   function automatic logic [31:0] nudge(input logic signed [31:0] base);
      longint v, t;
      int sgn;
      t = longint'(tol_model);
      sgn = $urandom_range(0, 1) ? 1 : -1;
      v = longint'(base);
      case ($urandom_range(0, 3))
         0: ;
         1: v = v + sgn * ((t > 0) ? t - 1 : 0);
         2: v = v + sgn * t;
         default: v = v + longint'($urandom_range(0, 131072)) - 65536;
      endcase
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic route_cmd_type make_near(input logic [1:0] cmd, input int pct_near);
      route_cmd_type q;
      int i;
      q.cmd = cmd;
      q.vmark = ($urandom_range(0, 3) != 0);
      if (route_count > 0 && $urandom_range(0, 99) < pct_near) begin
         i = $urandom_range(0, route_count - 1);
         q.sx = nudge(route_tbl[i].sx);
         q.sy = nudge(route_tbl[i].sy);
         q.ex = nudge(route_tbl[i].ex);
         q.ey = nudge(route_tbl[i].ey);
      end else begin
         q.sx = rand_coord();
         q.sy = rand_coord();
         q.ex = rand_coord();
         q.ey = rand_coord();
      end
      return q;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic [31:0] sx, input logic [31:0] sy,
                          input logic [31:0] ex, input logic [31:0] ey, input logic vmark,
                          input bit typed, input logic found, input logic [6:0] idx,
                          input logic dropped, input logic [7:0] count);
      stim_row_type row;
      row.c.cmd = cmd;
      row.c.sx = sx;
      row.c.sy = sy;
      row.c.ex = ex;
      row.c.ey = ey;
      row.c.vmark = vmark;
      row.typed = typed;
      row.r.found = found;
      row.r.idx = idx;
      row.r.dropped = dropped;
      row.r.count = count;
      rows.push_back(row);
   endtask

   // Called just after a rising edge; returns just after the accepting edge.
   task automatic send_command(input route_cmd_type c, input bit typed,
                               input route_reply_type typed_r);
      int gap;
      route_reply_type r;
      gap = idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.cmd;
      req_tdata <= {7'd0, c.vmark, c.ey, c.ex, c.sy, c.sx};
      do @(posedge clock); while (req_tready !== 1'b1);
      r = predict_route_reply(c);
      reply_q.push_back(typed ? typed_r : r);
      items_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      wait (rsp_seen == items_sent);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [30:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tol_model = value;
   endtask

   always @(posedge clock) begin : reply_check
      route_reply_type got_r;
      route_reply_type exp_r;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         rsp_seen++;
         got_r = route_reply_type'(rsp_tdata[16:0]);
         if (reply_q.size() == 0) begin
            report_mismatch("beat with nothing pending", 32'(rsp_tdata), 0);
         end else begin
            exp_r = reply_q.pop_front();
            if (got_r.found !== exp_r.found)
               report_mismatch("found", 32'(got_r.found), 32'(exp_r.found));
            if (got_r.idx !== exp_r.idx)
               report_mismatch("match_index", 32'(got_r.idx), 32'(exp_r.idx));
            if (got_r.dropped !== exp_r.dropped)
               report_mismatch("dropped", 32'(got_r.dropped), 32'(exp_r.dropped));
            if (got_r.count !== exp_r.count)
               report_mismatch("route_count", 32'(got_r.count), 32'(exp_r.count));
            if (rsp_tdata[23:17] !== '0)
               report_mismatch("pad bits", 32'(rsp_tdata[23:17]), 0);
         end
      end
   end

   // Receiver: random ready pattern, plus one long hold-off to back the block up.
   initial begin : receiver
      int run;
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && rsp_seen >= 60) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         run = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      route_cmd_type   c;
      route_reply_type none;
      logic [30:0]     tol;
      int              phase;
      int              fill;
      int              queries;
      none = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tolerance at its reset value here
      add_row(CMD_SEARCH, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0);
      add_row(CMD_UNUSED, '1, '1, '1, '1, 1, 1, 0, 0, 0, 0);
      add_row(CMD_APPEND, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 0, 0, 0, 1);
      add_row(CMD_APPEND, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1, 1, 0, 0, 0, 2);
      add_row(CMD_APPEND, 0, 0, 0, 0, 0, 1, 0, 0, 0, 3);
      add_row(CMD_APPEND, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1, 1, 0, 0, 0, 4);
      add_row(CMD_SEARCH, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 1, 1, 0, 0, 4);
      add_row(CMD_SEARCH, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1, 1, 1, 1, 0, 4);
      add_row(CMD_SEARCH, 0, 0, 0, 0, 1, 1, 0, 0, 0, 4);
      // full-scale differences must not wrap
      add_row(CMD_SEARCH, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1, 1, 0, 0, 0, 4);
      add_row(CMD_SEARCH, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX - 6553, 1, 0, 0, 0, 0, 0);
      add_row(CMD_SEARCH, COORD_MAX - 6554, COORD_MAX, COORD_MAX, COORD_MAX, 1, 0, 0, 0, 0, 0);
      add_row(CMD_SEARCH, COORD_MAX, COORD_MAX, COORD_MAX - 6553, COORD_MAX, 1, 0, 0, 0, 0, 0);
      add_row(CMD_UNUSED, 0, 0, 0, 0, 1, 1, 0, 0, 0, 4);
      add_row(CMD_APPEND, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_FFFF, 32'hFFFF_0000, 1,
              0, 0, 0, 0, 0);
      add_row(CMD_SEARCH, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_FFFF, 32'hFFFE_FFFF, 0,
              0, 0, 0, 0, 0);
      add_row(CMD_CLEAR, '1, '1, '1, '1, 1, 1, 0, 0, 0, 0);
      add_row(CMD_SEARCH, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 0, 0, 0, 0);
      add_row(CMD_APPEND, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1);
      add_row(CMD_SEARCH, 6553, -32'sd6553, 0, 0, 1, 0, 0, 0, 0, 0);

      foreach (rows[k]) send_command(rows[k].c, rows[k].typed, rows[k].r);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case (phase % 5)
            0: tol = '0;
            1: tol = 31'h7FFF_FFFF;
            2: tol = 31'($urandom_range(1, 200000));
            3: tol = 31'($urandom);
            default: tol = 31'd1;
         endcase
         write_tolerance(tol);
         if ($urandom_range(0, 3) != 0) begin
            c = make_near(CMD_CLEAR, 0);
            send_command(c, 0, none);
         end
         // every seventh phase overfills the table
         fill = (phase % 7 == 2) ? TABLE_DEPTH + $urandom_range(1, 4) : $urandom_range(1, 24);
         for (int n = 0; n < fill; n++) begin
            c = make_near(CMD_APPEND, 30);
            send_command(c, 0, none);
            if ($urandom_range(0, 4) == 0) begin
               c = make_near(CMD_SEARCH, 70);
               send_command(c, 0, none);
            end
         end
         queries = $urandom_range(8, 30);
         for (int n = 0; n < queries; n++) begin
            if ($urandom_range(0, 9) == 0) c = make_near(CMD_UNUSED, 0);
            else c = make_near(CMD_SEARCH, 75);
            send_command(c, 0, none);
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      wait (rsp_seen == items_sent);
      repeat (20) @(posedge clock);
      if (reply_q.size() != 0) report_mismatch("replies left pending", reply_q.size(), 0);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
